// File: hw/rtl/hsv_to_rgb_converter_top_assert.svh
// assertion macros shared by the hsv to rgb converter modules
// expects clk_i and rst_ni in the scope of each use
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold on every clock edge out of reset
`define HSVRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen out of reset
`define HSVRGB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HSVRGB_ASSERT(lbl, prop, msg)
`define HSVRGB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hw/rtl/hsvrgb_pkg.sv
// constants and types of the hsv to rgb converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

  // field widths
  localparam int HueW  = 14;
  localparam int SatW  = 12;
  localparam int ValW  = 12;
  localparam int ChanW = 8;

  // clamp limits and scales
  localparam int HueMax    = 5760;
  localparam int SvMax     = 1600;
  localparam int Sector    = 960;
  localparam int KMax      = 6;

  // internal widths
  localparam int HclW = 13;   // clamped hue 0..5760
  localparam int SvW  = 11;   // clamped sat / val 0..1600
  localparam int KW   = 3;    // sector 0..6
  localparam int FW   = 10;   // fraction 0..960
  localparam int CW   = 22;   // chroma, offset, x at full scale 2560000
  localparam int PW   = 32;   // chroma times fraction
  localparam int QW   = 26;   // product over 64
  localparam int YW   = 18;   // channel times 255 over 4096

  // reciprocal of 15 for 26-bit operands, shift 30
  localparam logic [26:0] Recip15  = 27'd71582789;
  localparam int          Recip15Sh = 30;
  // reciprocal of 625 for 18-bit operands, shift 28
  localparam logic [18:0] Recip625   = 19'd429497;
  localparam int          Recip625Sh = 28;

  // word passed from the front half to the back half
  typedef struct packed {
    logic [KW-1:0] k;
    logic [CW-1:0] c;
    logic [CW-1:0] m;
    logic [PW-1:0] p;
  } mid_t;

  // start of a hue sector
  function automatic logic [HclW-1:0] sector_base(input logic [KW-1:0] k);
    sector_base = HclW'(int'(k) * Sector);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hsvrgb_in_if.sv
// input channel of the converter: hue, saturation and value words
// depends on hsvrgb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hsvrgb_pkg::HueW-1:0]   hue_in;
  logic signed [hsvrgb_pkg::SatW-1:0]   saturation_in;
  logic signed [hsvrgb_pkg::ValW-1:0]   value_in;

  modport source (output valid, hue_in, saturation_in, value_in, input ready);
  modport sink   (input valid, hue_in, saturation_in, value_in, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hsvrgb_out_if.sv
// output channel of the converter: red, green and blue words
// depends on hsvrgb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_out_if;
  logic                            valid;
  logic                            ready;
  logic [hsvrgb_pkg::ChanW-1:0]    red_out;
  logic [hsvrgb_pkg::ChanW-1:0]    green_out;
  logic [hsvrgb_pkg::ChanW-1:0]    blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hsvrgb_front.sv
// front half of the pipeline: clamp, sector split, chroma, chroma times fraction
// depends on hsvrgb_pkg, hsvrgb_in_if and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_converter_top_assert.svh"

module hsvrgb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  hsvrgb_in_if.sink              pix_i,
  output hsvrgb_pkg::mid_t       mid_o,
  output logic                   mid_vld_o,
  input  wire logic              mid_rdy_i
);

  // stage advance, bubbles collapse
  logic adv1, adv2, adv3;
  logic st1_vld_q, st2_vld_q, st3_vld_q;

  assign adv3 = !st3_vld_q || mid_rdy_i;
  assign adv2 = !st2_vld_q || adv3;
  assign adv1 = !st1_vld_q || adv2;
  assign pix_i.ready = adv1;

  // clamp inputs
  logic [hsvrgb_pkg::HclW-1:0] hue_cl;
  logic [hsvrgb_pkg::SvW-1:0]  sat_cl, val_cl;

  always_comb begin
    if (pix_i.hue_in[hsvrgb_pkg::HueW-1]) begin
      hue_cl = '0;
    end else if (pix_i.hue_in[hsvrgb_pkg::HclW-1:0] > hsvrgb_pkg::HclW'(hsvrgb_pkg::HueMax)) begin
      hue_cl = hsvrgb_pkg::HclW'(hsvrgb_pkg::HueMax);
    end else begin
      hue_cl = pix_i.hue_in[hsvrgb_pkg::HclW-1:0];
    end
    if (pix_i.saturation_in[hsvrgb_pkg::SatW-1]) begin
      sat_cl = '0;
    end else if (pix_i.saturation_in[hsvrgb_pkg::SvW-1:0] > hsvrgb_pkg::SvW'(hsvrgb_pkg::SvMax)) begin
      sat_cl = hsvrgb_pkg::SvW'(hsvrgb_pkg::SvMax);
    end else begin
      sat_cl = pix_i.saturation_in[hsvrgb_pkg::SvW-1:0];
    end
    if (pix_i.value_in[hsvrgb_pkg::ValW-1]) begin
      val_cl = '0;
    end else if (pix_i.value_in[hsvrgb_pkg::SvW-1:0] > hsvrgb_pkg::SvW'(hsvrgb_pkg::SvMax)) begin
      val_cl = hsvrgb_pkg::SvW'(hsvrgb_pkg::SvMax);
    end else begin
      val_cl = pix_i.value_in[hsvrgb_pkg::SvW-1:0];
    end
  end

  // hue sector and offset inside it
  logic [hsvrgb_pkg::KW-1:0]   sec_k;
  logic [hsvrgb_pkg::HclW-1:0] sec_off;

  always_comb begin
    case (hue_cl) inside
      [13'd0:13'd959]:     sec_k = 3'd0;
      [13'd960:13'd1919]:  sec_k = 3'd1;
      [13'd1920:13'd2879]: sec_k = 3'd2;
      [13'd2880:13'd3839]: sec_k = 3'd3;
      [13'd3840:13'd4799]: sec_k = 3'd4;
      [13'd4800:13'd5759]: sec_k = 3'd5;
      default:             sec_k = 3'd6;
    endcase
    sec_off = hue_cl - hsvrgb_pkg::sector_base(sec_k);
  end

  // stage 1 registers
  logic [hsvrgb_pkg::KW-1:0] st1_k_q;
  logic [hsvrgb_pkg::FW-1:0] st1_f_q;
  logic [hsvrgb_pkg::SvW-1:0] st1_sat_q, st1_val_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      st1_k_q   <= sec_k;
      st1_f_q   <= sec_off[hsvrgb_pkg::FW-1:0];
      st1_sat_q <= sat_cl;
      st1_val_q <= val_cl;
    end
  end

  // chroma and mirrored fraction
  logic [hsvrgb_pkg::CW-1:0] chroma_d;
  logic [hsvrgb_pkg::FW-1:0] frac_d;

  assign chroma_d = hsvrgb_pkg::CW'(st1_sat_q) * hsvrgb_pkg::CW'(st1_val_q);
  assign frac_d   = st1_k_q[0] ? (hsvrgb_pkg::FW'(hsvrgb_pkg::Sector) - st1_f_q) : st1_f_q;

  // stage 2 registers
  logic [hsvrgb_pkg::KW-1:0]  st2_k_q;
  logic [hsvrgb_pkg::FW-1:0]  st2_frac_q;
  logic [hsvrgb_pkg::CW-1:0]  st2_c_q;
  logic [hsvrgb_pkg::SvW-1:0] st2_val_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      st2_k_q    <= st1_k_q;
      st2_frac_q <= frac_d;
      st2_c_q    <= chroma_d;
      st2_val_q  <= st1_val_q;
    end
  end

  // chroma times fraction and offset
  logic [hsvrgb_pkg::PW-1:0] prod_d;
  logic [hsvrgb_pkg::CW-1:0] offs_d;

  assign prod_d = hsvrgb_pkg::PW'(st2_c_q) * hsvrgb_pkg::PW'(st2_frac_q);
  assign offs_d = hsvrgb_pkg::CW'(st2_val_q) * hsvrgb_pkg::CW'(hsvrgb_pkg::SvMax) - st2_c_q;

  // stage 3 registers
  hsvrgb_pkg::mid_t st3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      st3_q.k <= st2_k_q;
      st3_q.c <= st2_c_q;
      st3_q.m <= offs_d;
      st3_q.p <= prod_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q <= 1'b0;
      st2_vld_q <= 1'b0;
      st3_vld_q <= 1'b0;
    end else begin
      if (adv1) st1_vld_q <= pix_i.valid;
      if (adv2) st2_vld_q <= st1_vld_q;
      if (adv3) st3_vld_q <= st2_vld_q;
    end
  end

  assign mid_o     = st3_q;
  assign mid_vld_o = st3_vld_q;

  // checks
  `HSVRGB_ASSERT(a_sector_range, st2_vld_q |-> st2_k_q <= 3'(hsvrgb_pkg::KMax), "sector out of range")
  `HSVRGB_ASSERT(a_frac_range, st2_vld_q |-> st2_frac_q <= 10'(hsvrgb_pkg::Sector), "fraction out of range")
  `HSVRGB_ASSERT(a_mid_hold, st3_vld_q && !mid_rdy_i |=> st3_vld_q && $stable(st3_q), "stalled word changed")

endmodule

`default_nettype wire

// File: hw/rtl/hsvrgb_back.sv
// back half of the pipeline: x by reciprocal, sector mapping, scaling to 8 bits
// depends on hsvrgb_pkg, hsvrgb_out_if and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_converter_top_assert.svh"

module hsvrgb_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hsvrgb_pkg::mid_t  mid_i,
  input  wire logic              mid_vld_i,
  output logic                   mid_rdy_o,
  hsvrgb_out_if.source           pix_o
);

  // sector codes
  localparam logic [2:0] SecRedYel = 3'd0;
  localparam logic [2:0] SecYelGrn = 3'd1;
  localparam logic [2:0] SecGrnCyn = 3'd2;
  localparam logic [2:0] SecCynBlu = 3'd3;
  localparam logic [2:0] SecBluMag = 3'd4;

  // stage advance
  logic adv4, adv5, adv6;
  logic st4_vld_q, st5_vld_q, st6_vld_q;

  assign adv6 = !st6_vld_q || pix_o.ready;
  assign adv5 = !st5_vld_q || adv6;
  assign adv4 = !st4_vld_q || adv5;
  assign mid_rdy_o = adv4;

  // x = p / 960 = (p / 64) / 15 by reciprocal
  logic [hsvrgb_pkg::QW-1:0] quo64;
  logic [52:0]               recip_prod;

  assign quo64      = mid_i.p[hsvrgb_pkg::PW-1:6];
  assign recip_prod = 53'(quo64) * 53'(hsvrgb_pkg::Recip15);

  // stage 4 registers
  logic [hsvrgb_pkg::KW-1:0] st4_k_q;
  logic [hsvrgb_pkg::CW-1:0] st4_c_q, st4_m_q, st4_x_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      st4_k_q <= mid_i.k;
      st4_c_q <= mid_i.c;
      st4_m_q <= mid_i.m;
      st4_x_q <= recip_prod[hsvrgb_pkg::Recip15Sh +: hsvrgb_pkg::CW];
    end
  end

  // sector mapping
  logic [hsvrgb_pkg::CW-1:0] ch_r, ch_g, ch_b;

  always_comb begin
    case (st4_k_q)
      SecRedYel: begin
        ch_r = st4_c_q; ch_g = st4_x_q; ch_b = '0;
      end
      SecYelGrn: begin
        ch_r = st4_x_q; ch_g = st4_c_q; ch_b = '0;
      end
      SecGrnCyn: begin
        ch_r = '0; ch_g = st4_c_q; ch_b = st4_x_q;
      end
      SecCynBlu: begin
        ch_r = '0; ch_g = st4_x_q; ch_b = st4_c_q;
      end
      SecBluMag: begin
        ch_r = st4_x_q; ch_g = '0; ch_b = st4_c_q;
      end
      default: begin
        ch_r = st4_c_q; ch_g = '0; ch_b = st4_x_q;
      end
    endcase
  end

  // add offset, times 255, over 4096
  logic [hsvrgb_pkg::CW-1:0] sum_r, sum_g, sum_b;
  logic [29:0]               scl_r, scl_g, scl_b;

  assign sum_r = ch_r + st4_m_q;
  assign sum_g = ch_g + st4_m_q;
  assign sum_b = ch_b + st4_m_q;
  assign scl_r = (30'(sum_r) << 8) - 30'(sum_r);
  assign scl_g = (30'(sum_g) << 8) - 30'(sum_g);
  assign scl_b = (30'(sum_b) << 8) - 30'(sum_b);

  // stage 5 registers
  logic [hsvrgb_pkg::YW-1:0] st5_r_q, st5_g_q, st5_b_q;

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      st5_r_q <= scl_r[29:12];
      st5_g_q <= scl_g[29:12];
      st5_b_q <= scl_b[29:12];
    end
  end

  // over 625 by reciprocal
  logic [36:0] div_r, div_g, div_b;

  assign div_r = 37'(st5_r_q) * 37'(hsvrgb_pkg::Recip625);
  assign div_g = 37'(st5_g_q) * 37'(hsvrgb_pkg::Recip625);
  assign div_b = 37'(st5_b_q) * 37'(hsvrgb_pkg::Recip625);

  // stage 6: output register
  logic [hsvrgb_pkg::ChanW-1:0] st6_r_q, st6_g_q, st6_b_q;

  always_ff @(posedge clk_i) begin
    if (adv6) begin
      st6_r_q <= div_r[hsvrgb_pkg::Recip625Sh +: hsvrgb_pkg::ChanW];
      st6_g_q <= div_g[hsvrgb_pkg::Recip625Sh +: hsvrgb_pkg::ChanW];
      st6_b_q <= div_b[hsvrgb_pkg::Recip625Sh +: hsvrgb_pkg::ChanW];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st4_vld_q <= 1'b0;
      st5_vld_q <= 1'b0;
      st6_vld_q <= 1'b0;
    end else begin
      if (adv4) st4_vld_q <= mid_vld_i;
      if (adv5) st5_vld_q <= st4_vld_q;
      if (adv6) st6_vld_q <= st5_vld_q;
    end
  end

  assign pix_o.valid     = st6_vld_q;
  assign pix_o.red_out   = st6_r_q;
  assign pix_o.green_out = st6_g_q;
  assign pix_o.blue_out  = st6_b_q;

  // checks
  `HSVRGB_ASSERT(a_x_below_c, st4_vld_q |-> st4_x_q <= st4_c_q, "x above chroma")
  `HSVRGB_ASSERT(a_scaled_range, st5_vld_q |-> st5_r_q <= 18'd159375 && st5_g_q <= 18'd159375 && st5_b_q <= 18'd159375, "scaled channel above full scale")
  `HSVRGB_ASSERT(a_st4_hold, st4_vld_q && !adv5 |=> st4_vld_q && $stable(st4_x_q), "stalled x changed")

endmodule

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter: an accepted word passes through six register stages
// (clamp/sector, chroma multiply, fraction multiply, reciprocal divide,
// channel scale, reciprocal divide into the output register) to its result
// on the output; one word per cycle is taken while the output is ready.
// reset clears only the stage valid bits; the pipeline is empty after reset
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_top (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  hsvrgb_in_if.sink      pix_in_i,
  hsvrgb_out_if.source   pix_out_o
);

  // link between the two halves
  hsvrgb_pkg::mid_t mid;
  logic             mid_vld;
  logic             mid_rdy;

  hsvrgb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_in_i),
    .mid_o     (mid),
    .mid_vld_o (mid_vld),
    .mid_rdy_i (mid_rdy)
  );

  hsvrgb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mid_i     (mid),
    .mid_vld_i (mid_vld),
    .mid_rdy_o (mid_rdy),
    .pix_o     (pix_out_o)
  );

endmodule

`default_nettype wire
